// ===== design/ihexv_pkg.sv =====
// ----------------------------------------------------------------------------
// ihexv_pkg
// shared types, codes and character helpers for the intel hex stream validator
// ----------------------------------------------------------------------------
package ihexv_pkg;

    localparam logic [1:0] ACT_CHAR    = 2'd0;
    localparam logic [1:0] ACT_EOF     = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [7:0] KIND_DATA       = 8'h00;
    localparam logic [7:0] KIND_END        = 8'h01;
    localparam logic [7:0] KIND_EXT_SEG    = 8'h02;
    localparam logic [7:0] KIND_START_SEG  = 8'h03;
    localparam logic [7:0] KIND_EXT_LIN    = 8'h04;
    localparam logic [7:0] KIND_START_LIN  = 8'h05;

    localparam logic [7:0] LEN_BASE  = 8'd2;
    localparam logic [7:0] LEN_START = 8'd4;

    localparam logic [7:0]  CHAR_COLON      = 8'h3a;
    localparam logic [31:0] MAX_IMAGE_RESET = 32'd131072;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FORMAT   = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_ADDRESS  = 3'd3,
        ST_ORDER    = 3'd4,
        ST_NO_END   = 3'd5
    } ihexv_status_t;

    typedef enum logic [7:0] {
        PH_COLON   = 8'b0000_0001,
        PH_LENGTH  = 8'b0000_0010,
        PH_ADDR_HI = 8'b0000_0100,
        PH_ADDR_LO = 8'b0000_1000,
        PH_KIND    = 8'b0001_0000,
        PH_DATA    = 8'b0010_0000,
        PH_CHECK   = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } ihexv_phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] character;
    } ihexv_item_t;

    typedef struct packed {
        ihexv_status_t status;
        logic [31:0]   padded_size;
    } ihexv_result_t;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

endpackage

// ===== design/ihexv_stream_if.sv =====
// ----------------------------------------------------------------------------
// ihexv stream interfaces
// valid/ready channels for characters, results and the size limit register
// ----------------------------------------------------------------------------
interface ihexv_char_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] character;

    modport source (output valid, output action, output character, input ready);
    modport sink   (input valid, input action, input character, output ready);
endinterface

interface ihexv_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] padded_size;

    modport source (output valid, output status, output padded_size, input ready);
    modport sink   (input valid, input status, input padded_size, output ready);
endinterface

interface ihexv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_image_bytes;

    modport source (output valid, output max_image_bytes, input ready);
    modport sink   (input valid, input max_image_bytes, output ready);
endinterface

// ===== design/ihexv_parser.sv =====
// ----------------------------------------------------------------------------
// ihexv_parser
// record parser state: hex decode, checksum, record rules; while step is high, one beat per cycle
// ----------------------------------------------------------------------------
module ihexv_parser
    import ihexv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  ihexv_item_t   item,
    input  logic [31:0]   max_image_bytes,
    output logic          res_valid,
    output ihexv_result_t res
);

    ihexv_phase_t phase_reg, phase_next;
    logic         held_reg, held_next;
    logic [4:0]   nib_reg, nib_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   off_hi_reg, off_hi_next;
    logic [7:0]   kind_reg, kind_next;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [15:0]  first_reg, first_next;
    logic [31:0]  seg_reg, seg_next;
    logic [31:0]  prev_end_reg, prev_end_next;
    logic [31:0]  high_end_reg, high_end_next;
    logic         seen_reg, seen_next;
    logic [31:0]  addr_reg, addr_next;
    logic [31:0]  end_reg, end_next;
    logic         wrap_reg, wrap_next;

    logic [4:0]   lo;
    logic [7:0]   b;
    logic [7:0]   cnt_inc;

    assign lo      = digit_value(item.character);
    assign b       = {nib_reg[3:0], lo[3:0]};
    assign cnt_inc = cnt_reg + 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        nib_next      = nib_reg;
        len_next      = len_reg;
        off_hi_next   = off_hi_reg;
        kind_next     = kind_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        first_next    = first_reg;
        seg_next      = seg_reg;
        prev_end_next = prev_end_reg;
        high_end_next = high_end_reg;
        seen_next     = seen_reg;
        addr_next     = addr_reg;
        end_next      = end_reg;
        wrap_next     = wrap_reg;
        res_valid     = 1'b0;
        res           = '{status: ST_OK, padded_size: 32'd0};

        if (step)
        begin
            priority if (item.action == ACT_RESTART)
            begin
                phase_next    = PH_COLON;
                held_next     = 1'b0;
                nib_next      = '0;
                len_next      = '0;
                off_hi_next   = '0;
                kind_next     = '0;
                sum_next      = '0;
                cnt_next      = '0;
                first_next    = '0;
                seg_next      = '0;
                prev_end_next = '0;
                high_end_next = '0;
                seen_next     = 1'b0;
            end
            else if (phase_reg == PH_DONE || !(item.action == ACT_EOF ||
                                               item.action == ACT_CHAR))
            begin
                phase_next = phase_reg;
            end
            else if (item.action == ACT_EOF)
            begin
                res_valid  = 1'b1;
                res.status = (phase_reg == PH_COLON) ? ST_NO_END : ST_FORMAT;
            end
            else if (phase_reg == PH_COLON)
            begin
                if (!is_blank(item.character))
                begin
                    if (item.character != CHAR_COLON)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_FORMAT;
                    end
                    else
                    begin
                        held_next  = 1'b0;
                        phase_next = PH_LENGTH;
                    end
                end
            end
            else if (!held_reg)
            begin
                nib_next  = lo;
                held_next = 1'b1;
            end
            else
            begin
                held_next = 1'b0;
                if (nib_reg[4] || lo[4])
                begin
                    res_valid  = 1'b1;
                    res.status = ST_FORMAT;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LENGTH:
                        begin
                            len_next   = b;
                            sum_next   = b;
                            phase_next = PH_ADDR_HI;
                        end
                        PH_ADDR_HI:
                        begin
                            off_hi_next = b;
                            sum_next    = sum_reg + b;
                            phase_next  = PH_ADDR_LO;
                        end
                        PH_ADDR_LO:
                        begin
                            addr_next  = seg_reg + {16'd0, off_hi_reg, b};
                            sum_next   = sum_reg + b;
                            phase_next = PH_KIND;
                        end
                        PH_KIND:
                        begin
                            {wrap_next, end_next} = {1'b0, addr_reg} + {25'd0, len_reg};
                            kind_next  = b;
                            sum_next   = sum_reg + b;
                            cnt_next   = '0;
                            first_next = '0;
                            phase_next = (len_reg == 8'd0) ? PH_CHECK : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (cnt_reg == 8'd0)
                            begin
                                first_next = {b, 8'd0};
                            end
                            else if (cnt_reg == 8'd1)
                            begin
                                first_next = {first_reg[15:8], b};
                            end
                            sum_next = sum_reg + b;
                            cnt_next = cnt_inc;
                            if (cnt_inc == len_reg)
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            phase_next = PH_COLON;
                            if (8'(sum_reg + b) != 8'd0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_CHECKSUM;
                            end
                            else if (kind_reg == KIND_DATA)
                            begin
                                if (wrap_reg || end_reg > max_image_bytes)
                                begin
                                    res_valid  = 1'b1;
                                    res.status = ST_ADDRESS;
                                end
                                else if (seen_reg && addr_reg < prev_end_reg)
                                begin
                                    res_valid  = 1'b1;
                                    res.status = ST_ORDER;
                                end
                                else if (len_reg != 8'd0)
                                begin
                                    seen_next     = 1'b1;
                                    prev_end_next = end_reg;
                                    if (end_reg > high_end_reg)
                                    begin
                                        high_end_next = end_reg;
                                    end
                                end
                            end
                            else if (kind_reg == KIND_END)
                            begin
                                res_valid = 1'b1;
                                if (len_reg != 8'd0 || !seen_reg)
                                begin
                                    res.status = ST_FORMAT;
                                end
                                else
                                begin
                                    res.status      = ST_OK;
                                    res.padded_size = (high_end_reg + 32'd1) & ~32'd1;
                                end
                            end
                            else if (kind_reg == KIND_EXT_SEG || kind_reg == KIND_EXT_LIN)
                            begin
                                if (len_reg != LEN_BASE)
                                begin
                                    res_valid  = 1'b1;
                                    res.status = ST_FORMAT;
                                end
                                else if (kind_reg == KIND_EXT_SEG)
                                begin
                                    seg_next = {12'd0, first_reg, 4'd0};
                                end
                                else
                                begin
                                    seg_next = {first_reg, 16'd0};
                                end
                            end
                            else if (kind_reg == KIND_START_SEG ||
                                     kind_reg == KIND_START_LIN)
                            begin
                                if (len_reg != LEN_START)
                                begin
                                    res_valid  = 1'b1;
                                    res.status = ST_FORMAT;
                                end
                            end
                            else
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_FORMAT;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end

            if (res_valid)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COLON;
            held_reg     <= 1'b0;
            nib_reg      <= '0;
            len_reg      <= '0;
            kind_reg     <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            first_reg    <= '0;
            seg_reg      <= '0;
            prev_end_reg <= '0;
            high_end_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            nib_reg      <= nib_next;
            len_reg      <= len_next;
            kind_reg     <= kind_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            seg_reg      <= seg_next;
            prev_end_reg <= prev_end_next;
            high_end_reg <= high_end_next;
            seen_reg     <= seen_next;
        end
    end

    // address words, always written before use
    always_ff @(posedge clk)
    begin
        off_hi_reg <= off_hi_next;
        addr_reg   <= addr_next;
        end_reg    <= end_next;
        wrap_reg   <= wrap_next;
    end

endmodule

// ===== design/intel_hex_stream_validator_top.sv =====
// ----------------------------------------------------------------------------
// intel_hex_stream_validator_top
// Accepts one character, end-of-file or restart beat per cycle. A beat is
// held in an input register until the parser takes it, and any result is
// loaded into an output register when that beat advances, so a result is
// never combinational from its beat. While a result waits in the output
// register the next beat is held in the input register and input stalls
// until the result is taken. Exactly one result is given per file (on the
// end record or the first error), then input is dropped until a restart
// beat. Write the size limit register only while idle.
// ----------------------------------------------------------------------------
module intel_hex_stream_validator_top
    import ihexv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ihexv_char_if.sink     chars,
    ihexv_result_if.source result,
    ihexv_cfg_if.sink      cfg
);

    logic          in_valid_reg;
    ihexv_item_t   in_item_reg;
    logic          out_valid_reg;
    ihexv_result_t out_reg;
    logic [31:0]   max_reg;

    logic          advance;
    logic          res_valid;
    ihexv_result_t res;

    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.status      = out_reg.status;
    assign result.padded_size = out_reg.padded_size;

    ihexv_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .item            (in_item_reg),
        .max_image_bytes (max_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= MAX_IMAGE_RESET;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                max_reg <= cfg.max_image_bytes;
            end
        end
    end

    // beat and result payloads
    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_item_reg <= '{action: chars.action, character: chars.character};
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule
